### hdl/dhm_pkg.sv
// Shared types and constants for the delta height grid core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dhm_pkg;

   localparam int GRID_SIDE_DEF     = 65;
   localparam int CELL_SIZE         = 8192;
   localparam int CELL_LOG2         = $clog2(CELL_SIZE);
   localparam int COORD_W           = 14;
   localparam int HEIGHT_W          = 24;
   localparam int SUM_W             = 32;
   localparam int SUM_FRAC          = 8;
   localparam int DELTA_W           = 8;
   localparam int RESULT_W          = 48;
   localparam int FRAC_BITS         = 14;
   localparam int HEIGHT_SCALE_LOG2 = 3;
   localparam int RESULT_OFFSET     = 16;
   localparam int UNLOADED_HEIGHT   = -256;

   localparam int DIFF_W     = HEIGHT_W + 1;
   localparam int PROD_W     = DIFF_W + COORD_W + 1;
   localparam int ACC_W      = PROD_W + 1;
   localparam int BASE_SHIFT = HEIGHT_SCALE_LOG2 + FRAC_BITS;
   localparam int ACC_SHIFT  = HEIGHT_SCALE_LOG2 + FRAC_BITS - CELL_LOG2;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_DELTA = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_READ_BASE,
      ST_READ_A,
      ST_MAC_A,
      ST_MAC_B,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### hdl/dhm_locate.sv
// Maps one cell-local coordinate to a grid vertex index and a fraction over the cell size.
// Depends on dhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhm_locate #(
   parameter int GRID_SIDE = dhm_pkg::GRID_SIDE_DEF,
   localparam int CNT_W = $clog2(GRID_SIDE + 1)
) (
   input  wire logic [dhm_pkg::COORD_W-1:0] coord,
   output logic      [CNT_W-1:0]            idx,
   output logic      [dhm_pkg::COORD_W-1:0] frac
);
   import dhm_pkg::*;

   localparam int S_W     = COORD_W + CNT_W;
   localparam int WHOLE_W = S_W - CELL_LOG2;

   logic [COORD_W-1:0] c_wrap;
   logic [S_W-1:0]     scaled;
   logic [WHOLE_W-1:0] whole;

   always_comb begin
      if (coord > COORD_W'(CELL_SIZE)) begin
         c_wrap = COORD_W'(coord[CELL_LOG2-1:0]);
      end else begin
         c_wrap = coord;
      end
      scaled = S_W'(c_wrap) * S_W'(GRID_SIDE - 1);
      whole  = scaled[S_W-1:CELL_LOG2];
      // far edge steps back one vertex with a full fraction
      if (whole >= WHOLE_W'(GRID_SIDE - 1)) begin
         idx  = CNT_W'(GRID_SIDE - 2);
         frac = COORD_W'(CELL_SIZE);
      end else begin
         idx  = whole[CNT_W-1:0];
         frac = COORD_W'(scaled[CELL_LOG2-1:0]);
      end
   end

endmodule

`default_nettype wire

### hdl/delta_heightmap_load_and_query_core.sv
// Top level: delta-coded height grid loader and triangle-split height query.
// Depends on dhm_pkg and dhm_locate.
`timescale 1ns / 1ps
`default_nettype none

// A begin word (0) starts a record; each delta word (1) writes the next grid entry until the
// grid is full; a query word (2) is accepted and the request side is then held not ready
// until its result is offered (and for as long before that as the previous result waits to
// be taken). The query sequence is set by the single read port of the grid memory, which
// fetches the three corners of the chosen triangle in turn, and by the one shared
// multiply-accumulate unit, used twice per query. The grid needs no clearing pass after
// reset or begin: entries beyond the current load position read as -256 before the first
// begin word and as zero after it.
module delta_heightmap_load_and_query_core #(
   parameter int GRID_SIDE = dhm_pkg::GRID_SIDE_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic        [1:0]                  req_cmd,
   input  wire logic signed [dhm_pkg::SUM_W-1:0]   req_base_offset,
   input  wire logic signed [dhm_pkg::DELTA_W-1:0] req_delta,
   input  wire logic        [dhm_pkg::COORD_W-1:0] req_query_x,
   input  wire logic        [dhm_pkg::COORD_W-1:0] req_query_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed      [dhm_pkg::RESULT_W-1:0] rsp_height_value
);
   import dhm_pkg::*;

   localparam int CNT_W  = $clog2(GRID_SIDE + 1);
   localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type state_ff, state_in;

   // load position and sums
   logic signed [SUM_W-1:0] row_start_ff, row_start_in;
   logic signed [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [CNT_W-1:0]        col_ff, col_in;
   logic [CNT_W-1:0]        row_ff, row_in;
   logic                    begun_ff, begun_in;

   // query registers
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic [CNT_W-1:0]   xi_ff, zi_ff;
   logic [COORD_W-1:0] px_ff, pz_ff;
   logic               near_ff;
   logic [COORD_W-1:0] u_ff, v_ff;
   logic signed [HEIGHT_W-1:0] base_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   // grid memory
   logic signed [HEIGHT_W-1:0] grid_mem [DEPTH];
   logic signed [HEIGHT_W-1:0] rd_q_ff;
   logic                       rd_hit_ff;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [HEIGHT_W-1:0] wr_data;
   logic [CNT_W-1:0]           rd_x, rd_y;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       rd_hit;
   logic signed [HEIGHT_W-1:0] eff_rd;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_value_ff, rsp_value_in;

   // sequencer controls
   logic load_loc, load_uv, load_base, mac_en, mac_first, rsp_load;

   logic [CNT_W-1:0]   loc_xi, loc_zi;
   logic [COORD_W-1:0] loc_px, loc_pz;
   logic [COORD_W:0]   frac_sum;

   logic accept;
   logic signed [SUM_W-1:0]    step;
   logic signed [SUM_W-1:0]    sum_new;
   logic                       round_up;
   logic signed [DIFF_W-1:0]   mul_a;
   logic signed [COORD_W:0]    mul_b;
   logic signed [PROD_W-1:0]   product;
   logic signed [RESULT_W-1:0] res_base, res_acc;

   dhm_locate #(.GRID_SIDE(GRID_SIDE)) u_locate_x (
      .coord (qx_ff),
      .idx   (loc_xi),
      .frac  (loc_px)
   );

   dhm_locate #(.GRID_SIDE(GRID_SIDE)) u_locate_y (
      .coord (qy_ff),
      .idx   (loc_zi),
      .frac  (loc_pz)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_QUERY)) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE:    state_in = ST_READ_BASE;
         ST_READ_BASE: state_in = ST_READ_A;
         ST_READ_A:    state_in = ST_MAC_A;
         ST_MAC_A:     state_in = ST_MAC_B;
         ST_MAC_B:     state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // corner order: near triangle base t1, then t2, b1; far triangle base b2, then b1, t2
   always_comb begin
      req_ready = 1'b0;
      load_loc  = 1'b0;
      load_uv   = 1'b0;
      load_base = 1'b0;
      mac_en    = 1'b0;
      mac_first = 1'b0;
      rsp_load  = 1'b0;
      rd_x      = xi_ff;
      rd_y      = zi_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOCATE: begin
            load_loc = 1'b1;
         end
         ST_READ_BASE: begin
            load_uv = 1'b1;
            if (!near_ff) begin
               rd_x = xi_ff + 1'b1;
               rd_y = zi_ff + 1'b1;
            end
         end
         ST_READ_A: begin
            load_base = 1'b1;
            if (near_ff) begin
               rd_x = xi_ff + 1'b1;
            end else begin
               rd_y = zi_ff + 1'b1;
            end
         end
         ST_MAC_A: begin
            mac_en    = 1'b1;
            mac_first = 1'b1;
            if (near_ff) begin
               rd_y = zi_ff + 1'b1;
            end else begin
               rd_x = xi_ff + 1'b1;
            end
         end
         ST_MAC_B: begin
            mac_en = 1'b1;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------- load path ----------------
   assign accept = req_valid && req_ready;
   assign step   = {{(SUM_W - DELTA_W - SUM_FRAC){req_delta[DELTA_W-1]}}, req_delta,
                    {SUM_FRAC{1'b0}}};

   always_comb begin
      row_start_in = row_start_ff;
      run_sum_in   = run_sum_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      begun_in     = begun_ff;
      wr_en        = 1'b0;
      sum_new      = run_sum_ff + step;
      if (col_ff == '0) begin
         sum_new = row_start_ff + step;
      end
      if (accept) begin
         case (req_cmd)
            CMD_BEGIN: begin
               row_start_in = req_base_offset;
               run_sum_in   = req_base_offset;
               col_in       = '0;
               row_in       = '0;
               begun_in     = 1'b1;
            end
            CMD_DELTA: begin
               if (row_ff < CNT_W'(GRID_SIDE)) begin
                  wr_en      = 1'b1;
                  run_sum_in = sum_new;
                  if (col_ff == '0) begin
                     row_start_in = sum_new;
                  end
                  if (col_ff == CNT_W'(GRID_SIDE - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // truncation toward zero of the 24.8 sum
   assign round_up = sum_new[SUM_W-1] && (sum_new[SUM_FRAC-1:0] != '0);
   assign wr_data  = sum_new[SUM_W-1:SUM_FRAC] + HEIGHT_W'(round_up);
   assign wr_addr  = ADDR_W'(col_ff) * ADDR_W'(GRID_SIDE) + ADDR_W'(row_ff);

   // ---------------- grid memory ----------------
   assign rd_addr = ADDR_W'(rd_x) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_y);
   assign rd_hit  = begun_ff && ((rd_y < row_ff) || ((rd_y == row_ff) && (rd_x < col_ff)));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_q_ff   <= grid_mem[rd_addr];
      rd_hit_ff <= rd_hit;
   end

   always_comb begin
      if (rd_hit_ff) begin
         eff_rd = rd_q_ff;
      end else if (begun_ff) begin
         eff_rd = '0;
      end else begin
         eff_rd = HEIGHT_W'(UNLOADED_HEIGHT);
      end
   end

   // ---------------- shared multiply-accumulate ----------------
   assign frac_sum = {1'b0, loc_px} + {1'b0, loc_pz};
   assign mul_a    = DIFF_W'(eff_rd) - DIFF_W'(base_ff);
   assign mul_b    = mac_first ? $signed({1'b0, u_ff}) : $signed({1'b0, v_ff});
   assign product  = mul_a * mul_b;
   assign acc_in   = (mac_first ? ACC_W'(0) : acc_ff) + ACC_W'(product);

   // height = base * 2^17 + 16 * (du + dv) + 16 in Q.14
   always_comb begin
      res_base     = RESULT_W'(base_ff);
      res_acc      = RESULT_W'(acc_ff);
      rsp_value_in = (res_base <<< BASE_SHIFT) + (res_acc <<< ACC_SHIFT)
                     + (RESULT_W'(RESULT_OFFSET) <<< FRAC_BITS);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_start_ff <= '0;
         run_sum_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= CNT_W'(GRID_SIDE);
         begun_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_start_ff <= row_start_in;
         run_sum_ff   <= run_sum_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         begun_ff     <= begun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff <= req_query_x;
         qy_ff <= req_query_y;
      end
      if (load_loc) begin
         xi_ff   <= loc_xi;
         zi_ff   <= loc_zi;
         px_ff   <= loc_px;
         pz_ff   <= loc_pz;
         near_ff <= (frac_sum <= (COORD_W + 1)'(CELL_SIZE));
      end
      if (load_uv) begin
         u_ff <= near_ff ? px_ff : COORD_W'(CELL_SIZE) - px_ff;
         v_ff <= near_ff ? pz_ff : COORD_W'(CELL_SIZE) - pz_ff;
      end
      if (load_base) begin
         base_ff <= eff_rd;
      end
      if (mac_en) begin
         acc_ff <= acc_in;
      end
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_height_value = rsp_value_ff;

endmodule

`default_nettype wire

### hdl/dhm_checker.sv
// Port-level checks for the delta height grid core, bound to the top level.
// Depends on dhm_pkg and delta_heightmap_load_and_query_core.
`timescale 1ns / 1ps
`default_nettype none

module dhm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic        [1:0]                  req_cmd,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [dhm_pkg::RESULT_W-1:0] rsp_height_value
);
   import dhm_pkg::*;

   // a waiting result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height_value))
      else $error("result word changed or dropped while stalled");

   // a query occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_QUERY) |=> !req_ready)
      else $error("ready while a query is in progress");

   // only queries produce results
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_QUERY) && !rsp_valid |=> !rsp_valid)
      else $error("result word without a query");

   // a new result appears only at the end of a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word appeared while idle");

endmodule

bind delta_heightmap_load_and_query_core dhm_checker u_dhm_checker (.*);

`default_nettype wire
